FILE: sv/swm_pkg.sv
`timescale 1ns / 1ps
// shared constants and types of the sliding window median filter
package swm_pkg;

  // default sizes
  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // window size register
  localparam int              CFG_BITS          = 7;
  localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RESET = 7'd3;

  // compare flags one sorter cell shows its neighbors
  typedef struct packed {
    logic big;   // own word sorts above the new word, or cell lies past the window
    logic bigu;  // same test after the oldest word is taken out
  } flags_t;

endpackage

FILE: sv/swm_if.sv
`timescale 1ns / 1ps
// stream interfaces for the sample feed and the median result
interface swm_in_if #(
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          end_of_stream;

  modport source (output valid, output sample, output end_of_stream, input ready);
  modport sink   (input valid, input sample, input end_of_stream, output ready);
endinterface

interface swm_out_if #(
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

FILE: sv/swm_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with registered read
module swm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/swm_cell.sv
`timescale 1ns / 1ps
// one cell of the sorted chain: holds one word, takes out the oldest and inserts the new one
module swm_cell #(
  parameter int IDX   = 0,
  parameter int WIDTH = 16,
  parameter int CW    = 7
) (
  input  logic                    clk,
  input  logic                    load,
  input  logic                    del,
  input  logic [CW-1:0]           limit,
  input  logic signed [WIDTH-1:0] s,
  input  logic signed [WIDTH-1:0] kold,
  input  logic signed [WIDTH-1:0] left_u,
  input  swm_pkg::flags_t         left_flags,
  input  logic signed [WIDTH-1:0] right_val,
  input  swm_pkg::flags_t         right_flags,
  output logic signed [WIDTH-1:0] val,
  output logic signed [WIDTH-1:0] u,
  output swm_pkg::flags_t         flags
);

  logic                    ge;
  logic signed [WIDTH-1:0] val_next;

  // compare against the new word; cells past the window act as empty
  assign flags.big = (CW'(IDX) >= limit) || (val > s);

  // the oldest word sits at or below this cell, so the word above slides down
  assign ge         = del && (val >= kold);
  assign u          = ge ? right_val : val;
  assign flags.bigu = ge ? right_flags.big : flags.big;

  // insert the new word where the order breaks, shift the rest up
  always_comb begin
    if (!flags.bigu) begin
      val_next = u;
    end else if (IDX == 0 || !left_flags.bigu) begin
      val_next = s;
    end else begin
      val_next = left_u;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      val <= val_next;
    end
  end

endmodule

FILE: sv/sliding_window_median.sv
`timescale 1ns / 1ps
// sliding window median filter: ring ram for age order plus a sorted chain of cells
//
//  port      dir   words              accepted when
//  feed      in    sample, eos flag   feed.valid && feed.ready
//  result    out   median             result.valid && result.ready
//  cfg       in    window_size        cfg_wr_en
//
// an item passes through accept and ring read, chain update, median select
// the ring read of the oldest word sets the split into accept and update cycles
// feed is taken again while a finished median still waits in the output register
// a stalled result holds the next item in the select cycle until the register frees
// synchronous reset empties the window and sets window_size to three
module sliding_window_median #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  swm_in_if.sink                        feed,
  swm_out_if.source                     result,
  input  logic                          cfg_wr_en,
  input  logic [swm_pkg::CFG_BITS-1:0]  cfg_wr_data
);

  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int PW = $clog2(WINDOW_MAX);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_UPD  = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t                         state, state_next;
  logic [swm_pkg::CFG_BITS-1:0]   window_size;
  logic [CW-1:0]                  fill, fill_next;
  logic [PW-1:0]                  ptr, ptr_next;
  logic [CW-1:0]                  ptr_inc;
  logic [CW-1:0]                  w_eff;
  logic [CW-1:0]                  mid;
  logic [CW-1:0]                  limit;
  logic                           full;
  logic                           has_result;
  logic                           eos_reg;
  logic signed [SAMPLE_BITS-1:0]  s_reg;
  logic [PW-1:0]                  addr_reg;
  logic [PW-1:0]                  rd_addr;
  logic [SAMPLE_BITS-1:0]         old_word;
  logic                           out_valid;
  logic signed [SAMPLE_BITS-1:0]  out_data;
  logic                           accept;
  logic                           load_out;

  logic signed [SAMPLE_BITS-1:0]  cell_val [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0]  cell_u   [WINDOW_MAX];
  swm_pkg::flags_t                cell_flg [WINDOW_MAX];

  // effective window size: zero means one, above the chain length saturates
  always_comb begin
    if (window_size == '0) begin
      w_eff = CW'(1);
    end else if (32'(window_size) > WINDOW_MAX) begin
      w_eff = CW'(WINDOW_MAX);
    end else begin
      w_eff = CW'(window_size);
    end
  end

  assign mid     = (w_eff - CW'(1)) >> 1;
  assign full    = (fill >= w_eff);
  assign limit   = full ? w_eff : fill;
  assign ptr_inc = CW'(ptr) + CW'(1);
  assign rd_addr = full ? ptr : fill[PW-1:0];

  // handshakes
  assign accept       = feed.valid && feed.ready;
  assign feed.ready   = (state == S_IDLE);
  assign load_out     = (state == S_OUT) && has_result && (!out_valid || result.ready);
  assign result.valid = out_valid;
  assign result.median = out_data;

  // ring of samples in arrival order, read for the word that leaves the window
  swm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (state == S_UPD),
    .waddr (addr_reg),
    .wdata (s_reg),
    .raddr (rd_addr),
    .rdata (old_word)
  );

  // sorted chain, ascending from cell zero
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] l_u;
    swm_pkg::flags_t               l_f;
    logic signed [SAMPLE_BITS-1:0] r_v;
    swm_pkg::flags_t               r_f;

    if (i == 0) begin : g_first
      assign l_u = s_reg;
      assign l_f = '0;
    end else begin : g_mid
      assign l_u = cell_u[i-1];
      assign l_f = cell_flg[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_last
      assign r_v = cell_val[i];
      assign r_f = '1;
    end else begin : g_inner
      assign r_v = cell_val[i+1];
      assign r_f = cell_flg[i+1];
    end

    swm_cell #(
      .IDX   (i),
      .WIDTH (SAMPLE_BITS),
      .CW    (CW)
    ) u_cell (
      .clk         (clk),
      .load        (state == S_UPD),
      .del         (full),
      .limit       (limit),
      .s           (s_reg),
      .kold        ($signed(old_word)),
      .left_u      (l_u),
      .left_flags  (l_f),
      .right_val   (r_v),
      .right_flags (r_f),
      .val         (cell_val[i]),
      .u           (cell_u[i]),
      .flags       (cell_flg[i])
    );
  end

  // fill count and oldest pointer after the current word
  always_comb begin
    fill_next = fill;
    ptr_next  = ptr;
    if (full) begin
      fill_next = w_eff;
      ptr_next  = (ptr_inc >= w_eff) ? '0 : ptr_inc[PW-1:0];
    end else begin
      fill_next = fill + CW'(1);
      ptr_next  = '0;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!has_result || load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      window_size <= swm_pkg::WINDOW_SIZE_RESET;
      fill        <= '0;
      ptr         <= '0;
      has_result  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        window_size <= cfg_wr_data;
        fill        <= '0;
        ptr         <= '0;
      end else if (state == S_UPD) begin
        has_result <= (fill_next >= w_eff);
        if (eos_reg) begin
          fill <= '0;
          ptr  <= '0;
        end else begin
          fill <= fill_next;
          ptr  <= ptr_next;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s_reg    <= feed.sample;
      eos_reg  <= feed.end_of_stream;
      addr_reg <= rd_addr;
    end
    if (load_out) begin
      out_data <= cell_val[mid[PW-1:0]];
    end
  end

  // checks
  a_accept_to_update: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_UPD))
    else $error("accepted word did not start an update");

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    fill <= w_eff)
    else $error("fill count above window size");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    CW'(ptr) < w_eff)
    else $error("oldest pointer outside window");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    ((state == S_OUT) && has_result && !out_valid) |=> out_valid)
    else $error("median not loaded into free output register");

endmodule
